### hdl/mp2a_pkg.sv
package mp2a_pkg;

  // Storage geometry
  localparam int MAX_WIDTH      = 256;
  localparam int MAX_POOL       = 8;
  localparam int SAMPLE_BITS    = 16;
  localparam int POOL_BITS      = $clog2(MAX_POOL);
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int BANK_ADDR_BITS = COL_BITS;
  localparam int BANK_DEPTH     = 2 ** BANK_ADDR_BITS;

  // Field and register widths
  localparam int WIN_BITS       = 4;
  localparam int STEP_BITS      = 4;
  localparam int DIM_BITS       = 9;
  localparam int ROW_BITS       = 9;
  localparam int IDX_BITS       = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;

  // Iterative divider geometry
  localparam int DIV_BITS       = 9;
  localparam int DIV_CNT_BITS   = $clog2(DIV_BITS);

  // Register defaults
  localparam logic [WIN_BITS-1:0]  WINDOW_RESET = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_RESET   = 4'd2;
  localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 9'd256;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 9'd256;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WINDOW_SIZE  = 2'd0,
    CFG_STEP         = 2'd1,
    CFG_PLANE_WIDTH  = 2'd2,
    CFG_PLANE_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic corner_hit;
    logic scan_last;
    logic div_done;
    logic on_grid;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic                          vld;
    logic signed [SAMPLE_BITS-1:0] val;
    logic [POOL_BITS-1:0]          idx;
  } cand_t;

endpackage

### hdl/max_pool_2d_argmax_core.sv
// A sample at a window corner, on the stride grid or not, stalls input while the window
//   is scanned and the 9-step pooled index dividers run alongside; an on-grid result
//   is registered once both finish, and may wait on a stalled output.
//   Other samples pass without a stall.
// Reset (rst, synchronous, active high): counters to zero, registers to their defaults;
//   the line store is not cleared and holds data only once written.
module max_pool_2d_argmax_core (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      sample_valid,
  output logic                                      sample_stall,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0]   sample,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0]   max_value,
  output logic [mp2a_pkg::IDX_BITS-1:0]             out_row,
  output logic [mp2a_pkg::IDX_BITS-1:0]             out_col,
  output logic [mp2a_pkg::IDX_BITS-1:0]             channel_index,
  output logic [mp2a_pkg::IDX_BITS-1:0]             argmax_row,
  output logic [mp2a_pkg::IDX_BITS-1:0]             argmax_col,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [mp2a_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

  mp2a_pkg::cmd_t    cmd;
  mp2a_pkg::status_t status;

  mp2a_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mp2a_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample        (sample),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .max_value     (max_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .channel_index (channel_index),
    .argmax_row    (argmax_row),
    .argmax_col    (argmax_col)
  );

endmodule

### hdl/mp2a_div.sv
module mp2a_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [mp2a_pkg::DIV_BITS-1:0]       dividend,
  input  logic [mp2a_pkg::STEP_BITS-1:0]      divisor,
  output logic [mp2a_pkg::DIV_BITS-1:0]       quotient,
  output logic [mp2a_pkg::STEP_BITS-1:0]      remainder,
  output logic                                done
);

  logic                                 busy;
  logic [mp2a_pkg::DIV_CNT_BITS-1:0]    count;
  logic [mp2a_pkg::STEP_BITS-1:0]       dvsr;
  logic [mp2a_pkg::STEP_BITS:0]         trial;
  logic                                 fits;

  // One restoring step: shift next dividend bit into the partial remainder
  always_comb begin
    trial = {remainder, quotient[mp2a_pkg::DIV_BITS-1]};
    fits  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      count     <= '0;
      remainder <= '0;
      quotient  <= dividend;
      dvsr      <= divisor;
    end else if (busy) begin
      remainder <= fits ? mp2a_pkg::STEP_BITS'(trial - {1'b0, dvsr})
                        : trial[mp2a_pkg::STEP_BITS-1:0];
      quotient  <= {quotient[mp2a_pkg::DIV_BITS-2:0], fits};
      count     <= count + mp2a_pkg::DIV_CNT_BITS'(1);
      if (count == mp2a_pkg::DIV_CNT_BITS'(mp2a_pkg::DIV_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

### hdl/mp2a_datapath.sv
module mp2a_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mp2a_pkg::cmd_t                            cmd,
  output mp2a_pkg::status_t                         status,
  input  logic signed [mp2a_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [mp2a_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output logic signed [mp2a_pkg::SAMPLE_BITS-1:0]   max_value,
  output logic [mp2a_pkg::IDX_BITS-1:0]             out_row,
  output logic [mp2a_pkg::IDX_BITS-1:0]             out_col,
  output logic [mp2a_pkg::IDX_BITS-1:0]             channel_index,
  output logic [mp2a_pkg::IDX_BITS-1:0]             argmax_row,
  output logic [mp2a_pkg::IDX_BITS-1:0]             argmax_col
);

  // Configuration registers and their effective values
  logic [mp2a_pkg::WIN_BITS-1:0]   window_size;
  logic [mp2a_pkg::STEP_BITS-1:0]  step;
  logic [mp2a_pkg::DIM_BITS-1:0]   plane_width;
  logic [mp2a_pkg::DIM_BITS-1:0]   plane_height;
  logic [mp2a_pkg::WIN_BITS-1:0]   p_eff;
  logic [mp2a_pkg::STEP_BITS-1:0]  s_eff;
  logic [mp2a_pkg::DIM_BITS-1:0]   w_eff;
  logic [mp2a_pkg::DIM_BITS-1:0]   h_eff;

  // Position counters
  logic [mp2a_pkg::ROW_BITS-1:0]   row_cnt;
  logic [mp2a_pkg::COL_BITS-1:0]   col_cnt;
  logic [mp2a_pkg::IDX_BITS-1:0]   chan_cnt;
  logic [mp2a_pkg::ROW_BITS-1:0]   row_inc;
  logic [mp2a_pkg::DIM_BITS-1:0]   col_inc;
  logic [mp2a_pkg::ROW_BITS-1:0]   r0_calc;
  logic [mp2a_pkg::COL_BITS-1:0]   c0_calc;

  // Window being scanned
  logic [mp2a_pkg::ROW_BITS-1:0]   win_r0;
  logic [mp2a_pkg::COL_BITS-1:0]   win_c0;
  logic [mp2a_pkg::IDX_BITS-1:0]   win_chan;
  logic [mp2a_pkg::POOL_BITS-1:0]  scan_row;
  logic [mp2a_pkg::ROW_BITS-1:0]   scan_r;

  // Read pipeline and running best
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] rd_data [mp2a_pkg::MAX_POOL];
  logic                                    rd_valid;
  logic                                    rd_first;
  logic [mp2a_pkg::ROW_BITS-1:0]           rd_row;
  mp2a_pkg::cand_t                         tree [2*mp2a_pkg::MAX_POOL-1];
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] best_val;
  logic [mp2a_pkg::ROW_BITS-1:0]           best_row;
  logic [mp2a_pkg::COL_BITS-1:0]           best_col;

  // Dividers for pooled index and grid check
  logic [mp2a_pkg::DIV_BITS-1:0]   q_r;
  logic [mp2a_pkg::DIV_BITS-1:0]   q_c;
  logic [mp2a_pkg::STEP_BITS-1:0]  rem_r;
  logic [mp2a_pkg::STEP_BITS-1:0]  rem_c;
  logic                            done_r;
  logic                            done_c;

  function automatic mp2a_pkg::cand_t pick(mp2a_pkg::cand_t a, mp2a_pkg::cand_t b);
    // ties keep the left (earlier) candidate
    return (b.vld && (!a.vld || b.val > a.val)) ? b : a;
  endfunction

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= mp2a_pkg::WINDOW_RESET;
      step         <= mp2a_pkg::STEP_RESET;
      plane_width  <= mp2a_pkg::WIDTH_RESET;
      plane_height <= mp2a_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mp2a_pkg::cfg_reg_t'(cfg_index))
        mp2a_pkg::CFG_WINDOW_SIZE:  window_size  <= cfg_data[mp2a_pkg::WIN_BITS-1:0];
        mp2a_pkg::CFG_STEP:         step         <= cfg_data[mp2a_pkg::STEP_BITS-1:0];
        mp2a_pkg::CFG_PLANE_WIDTH:  plane_width  <= cfg_data;
        mp2a_pkg::CFG_PLANE_HEIGHT: plane_height <= cfg_data;
      endcase
    end
  end

  // Clamp geometry: zero means one, window and width saturate
  always_comb begin
    if (window_size == '0)
      p_eff = mp2a_pkg::WIN_BITS'(1);
    else if (window_size > mp2a_pkg::WIN_BITS'(mp2a_pkg::MAX_POOL))
      p_eff = mp2a_pkg::WIN_BITS'(mp2a_pkg::MAX_POOL);
    else
      p_eff = window_size;
    s_eff = (step == '0) ? mp2a_pkg::STEP_BITS'(1) : step;
    if (plane_width == '0)
      w_eff = mp2a_pkg::DIM_BITS'(1);
    else if (plane_width > mp2a_pkg::DIM_BITS'(mp2a_pkg::MAX_WIDTH))
      w_eff = mp2a_pkg::DIM_BITS'(mp2a_pkg::MAX_WIDTH);
    else
      w_eff = plane_width;
    h_eff = (plane_height == '0) ? mp2a_pkg::DIM_BITS'(1) : plane_height;
  end

  // Next raster position and top-left of the window
  always_comb begin
    row_inc = row_cnt + mp2a_pkg::ROW_BITS'(1);
    col_inc = {1'b0, col_cnt} + mp2a_pkg::DIM_BITS'(1);
    r0_calc = row_inc - mp2a_pkg::ROW_BITS'(p_eff);
    c0_calc = mp2a_pkg::COL_BITS'(col_inc - mp2a_pkg::DIM_BITS'(p_eff));
  end

  // Raster counters advance on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      chan_cnt <= '0;
    end else if (cmd.accept) begin
      if (col_inc >= w_eff) begin
        col_cnt <= '0;
        if (row_inc >= h_eff) begin
          row_cnt  <= '0;
          chan_cnt <= chan_cnt + mp2a_pkg::IDX_BITS'(1);
        end else begin
          row_cnt <= row_inc;
        end
      end else begin
        col_cnt <= col_inc[mp2a_pkg::COL_BITS-1:0];
      end
    end
  end

  // Capture window origin; step through window rows
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_r0   <= r0_calc;
      win_c0   <= c0_calc;
      win_chan <= chan_cnt;
      scan_row <= '0;
    end else if (cmd.scan) begin
      scan_row <= scan_row + mp2a_pkg::POOL_BITS'(1);
    end
  end

  assign scan_r = win_r0 + mp2a_pkg::ROW_BITS'(scan_row);

  // Line store: one bank per column residue, so a window row hits each bank once
  for (genvar b = 0; b < mp2a_pkg::MAX_POOL; b++) begin : g_bank
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] mem [mp2a_pkg::BANK_DEPTH];
    logic [mp2a_pkg::POOL_BITS-1:0]          off;
    logic [mp2a_pkg::COL_BITS-1:0]           col_b;
    logic [mp2a_pkg::BANK_ADDR_BITS-1:0]     rd_addr;
    logic [mp2a_pkg::BANK_ADDR_BITS-1:0]     wr_addr;
    logic                                    wr_en;

    assign off     = mp2a_pkg::POOL_BITS'(b) - win_c0[mp2a_pkg::POOL_BITS-1:0];
    assign col_b   = win_c0 + mp2a_pkg::COL_BITS'(off);
    assign rd_addr = {scan_r[mp2a_pkg::POOL_BITS-1:0],
                      col_b[mp2a_pkg::COL_BITS-1:mp2a_pkg::POOL_BITS]};
    assign wr_addr = {row_cnt[mp2a_pkg::POOL_BITS-1:0],
                      col_cnt[mp2a_pkg::COL_BITS-1:mp2a_pkg::POOL_BITS]};
    assign wr_en   = cmd.accept &&
                     (col_cnt[mp2a_pkg::POOL_BITS-1:0] == mp2a_pkg::POOL_BITS'(b));

    always_ff @(posedge clk) begin
      if (wr_en)
        mem[wr_addr] <= sample;
      if (cmd.scan)
        rd_data[b] <= mem[rd_addr];
    end
  end

  // Read pipeline tags
  always_ff @(posedge clk) begin
    if (rst)
      rd_valid <= 1'b0;
    else
      rd_valid <= cmd.scan;
    rd_first <= (scan_row == '0);
    rd_row   <= scan_r;
  end

  // Rotate banks into window column order, then first-max tree
  always_comb begin
    logic [mp2a_pkg::POOL_BITS-1:0] sel;
    for (int o = 0; o < mp2a_pkg::MAX_POOL; o++) begin
      sel = win_c0[mp2a_pkg::POOL_BITS-1:0] + mp2a_pkg::POOL_BITS'(o);
      tree[mp2a_pkg::MAX_POOL-1+o].vld = (mp2a_pkg::WIN_BITS'(o) < p_eff);
      tree[mp2a_pkg::MAX_POOL-1+o].val = rd_data[sel];
      tree[mp2a_pkg::MAX_POOL-1+o].idx = mp2a_pkg::POOL_BITS'(o);
    end
    for (int n = mp2a_pkg::MAX_POOL-2; n >= 0; n--)
      tree[n] = pick(tree[2*n+1], tree[2*n+2]);
  end

  // Running best over window rows; later rows win only when strictly greater
  always_ff @(posedge clk) begin
    if (rd_valid && (rd_first || tree[0].val > best_val)) begin
      best_val <= tree[0].val;
      best_row <= rd_row;
      best_col <= win_c0 + mp2a_pkg::COL_BITS'(tree[0].idx);
    end
  end

  mp2a_div u_div_row (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.accept),
    .dividend  (r0_calc),
    .divisor   (s_eff),
    .quotient  (q_r),
    .remainder (rem_r),
    .done      (done_r)
  );

  mp2a_div u_div_col (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.accept),
    .dividend  (mp2a_pkg::DIV_BITS'(c0_calc)),
    .divisor   (s_eff),
    .quotient  (q_c),
    .remainder (rem_c),
    .done      (done_c)
  );

  // Status back to the controller
  assign status = '{
    corner_hit: (row_inc >= mp2a_pkg::ROW_BITS'(p_eff)) &&
                (col_inc >= mp2a_pkg::DIM_BITS'(p_eff)),
    scan_last:  (mp2a_pkg::WIN_BITS'(scan_row) == p_eff - mp2a_pkg::WIN_BITS'(1)),
    div_done:   done_r && done_c,
    on_grid:    (rem_r == '0) && (rem_c == '0),
    out_free:   !result_valid || !result_stall
  };

  // Output register
  always_ff @(posedge clk) begin
    if (rst)
      result_valid <= 1'b0;
    else if (cmd.load_out)
      result_valid <= 1'b1;
    else if (!result_stall)
      result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      max_value     <= best_val;
      out_row       <= q_r[mp2a_pkg::IDX_BITS-1:0];
      out_col       <= q_c[mp2a_pkg::IDX_BITS-1:0];
      channel_index <= win_chan;
      argmax_row    <= best_row[mp2a_pkg::IDX_BITS-1:0];
      argmax_col    <= best_col;
    end
  end

  // A new result never overwrites one still waiting for its transfer
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || !result_stall))
    else $error("result loaded over a pending result");

  // The last window row read lands in the pipeline the cycle after issue
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && status.scan_last) |=> rd_valid)
    else $error("last window row not in read pipeline");

  // Accepting an item restarts both dividers
  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !status.div_done)
    else $error("divider done right after restart");

endmodule

### hdl/mp2a_ctrl.sv
module mp2a_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  mp2a_pkg::status_t   status,
  output mp2a_pkg::cmd_t      cmd
);

  mp2a_pkg::state_t state;
  mp2a_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst)
      state <= mp2a_pkg::ST_IDLE;
    else
      state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mp2a_pkg::ST_IDLE: begin
        if (sample_valid && status.corner_hit)
          state_next = mp2a_pkg::ST_SCAN;
      end
      mp2a_pkg::ST_SCAN: begin
        if (status.scan_last)
          state_next = mp2a_pkg::ST_DRAIN;
      end
      mp2a_pkg::ST_DRAIN: begin
        state_next = mp2a_pkg::ST_FINISH;
      end
      mp2a_pkg::ST_FINISH: begin
        if (status.div_done && (!status.on_grid || status.out_free))
          state_next = mp2a_pkg::ST_IDLE;
      end
      default: state_next = mp2a_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    sample_stall = (state != mp2a_pkg::ST_IDLE);
    cmd.accept   = (state == mp2a_pkg::ST_IDLE) && sample_valid;
    cmd.scan     = (state == mp2a_pkg::ST_SCAN);
    cmd.load_out = (state == mp2a_pkg::ST_FINISH) && status.div_done &&
                   status.on_grid && status.out_free;
  end

endmodule

### sim/max_pool_2d_argmax_core_tb.sv
module max_pool_2d_argmax_core_tb;

  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] max_value;
    logic [mp2a_pkg::IDX_BITS-1:0]           out_row;
    logic [mp2a_pkg::IDX_BITS-1:0]           out_col;
    logic [mp2a_pkg::IDX_BITS-1:0]           channel_index;
    logic [mp2a_pkg::IDX_BITS-1:0]           argmax_row;
    logic [mp2a_pkg::IDX_BITS-1:0]           argmax_col;
  } pool_result_t;

  logic                                    clk = 1'b0;
  logic                                    rst = 1'b1;
  logic                                    sample_valid = 1'b0;
  logic                                    sample_stall;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic                                    result_valid;
  logic                                    result_stall = 1'b0;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] max_value;
  logic [mp2a_pkg::IDX_BITS-1:0]           out_row;
  logic [mp2a_pkg::IDX_BITS-1:0]           out_col;
  logic [mp2a_pkg::IDX_BITS-1:0]           channel_index;
  logic [mp2a_pkg::IDX_BITS-1:0]           argmax_row;
  logic [mp2a_pkg::IDX_BITS-1:0]           argmax_col;
  logic                                    cfg_valid = 1'b0;
  logic                                    cfg_ready;
  logic [mp2a_pkg::CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [mp2a_pkg::CFG_DATA_BITS-1:0]      cfg_data = '0;

  max_pool_2d_argmax_core dut (.*);

  // Clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Pooling predictor state: line store copy, raster position, register shadows
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] pool_mem [mp2a_pkg::MAX_POOL*mp2a_pkg::MAX_WIDTH];
  int unsigned                             row_pos = 0;
  int unsigned                             col_pos = 0;
  logic [mp2a_pkg::IDX_BITS-1:0]           plane_count = '0;
  logic [mp2a_pkg::WIN_BITS-1:0]           cfg_window = mp2a_pkg::WINDOW_RESET;
  logic [mp2a_pkg::STEP_BITS-1:0]          cfg_step = mp2a_pkg::STEP_RESET;
  logic [mp2a_pkg::DIM_BITS-1:0]           cfg_width = mp2a_pkg::WIDTH_RESET;
  logic [mp2a_pkg::DIM_BITS-1:0]           cfg_height = mp2a_pkg::HEIGHT_RESET;

  pool_result_t pending_windows[$];
  int           fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  int           hold_request = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int           burst_left = 0;
  pool_result_t got_window;

  function automatic int unsigned slot(input int unsigned r, input int unsigned c);
    return (r % mp2a_pkg::MAX_POOL) * mp2a_pkg::MAX_WIDTH + (c % mp2a_pkg::MAX_WIDTH);
  endfunction

  // Store the sample, scan a completed on-grid window, advance the raster position
  task automatic pool_sample(input logic signed [mp2a_pkg::SAMPLE_BITS-1:0] value);
    int unsigned win, stride, width, height, r0, c0, best_r, best_c, dr, dc;
    logic signed [mp2a_pkg::SAMPLE_BITS-1:0] best, cand;
    pool_result_t res;
    win    = (cfg_window == 0) ? 1 :
             ((cfg_window > mp2a_pkg::MAX_POOL) ? mp2a_pkg::MAX_POOL : cfg_window);
    stride = (cfg_step == 0) ? 1 : cfg_step;
    width  = (cfg_width == 0) ? 1 :
             ((cfg_width > mp2a_pkg::MAX_WIDTH) ? mp2a_pkg::MAX_WIDTH : cfg_width);
    height = (cfg_height == 0) ? 1 : cfg_height;
    pool_mem[slot(row_pos, col_pos)] = value;
    if (row_pos + 1 >= win && col_pos + 1 >= win) begin
      r0 = row_pos + 1 - win;
      c0 = col_pos + 1 - win;
      if (r0 % stride == 0 && c0 % stride == 0) begin
        // first element always taken; later ones only when strictly larger
        best = pool_mem[slot(r0, c0)];
        best_r = r0;
        best_c = c0;
        for (dr = 0; dr < win; dr++) begin
          for (dc = 0; dc < win; dc++) begin
            cand = pool_mem[slot(r0 + dr, c0 + dc)];
            if (cand > best) begin
              best = cand;
              best_r = r0 + dr;
              best_c = c0 + dc;
            end
          end
        end
        res.max_value     = best;
        res.out_row       = mp2a_pkg::IDX_BITS'(r0 / stride);
        res.out_col       = mp2a_pkg::IDX_BITS'(c0 / stride);
        res.channel_index = plane_count;
        res.argmax_row    = mp2a_pkg::IDX_BITS'(best_r);
        res.argmax_col    = mp2a_pkg::IDX_BITS'(best_c);
        pending_windows.push_back(res);
      end
    end
    col_pos++;
    if (col_pos >= width) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= height) begin
        row_pos = 0;
        plane_count++;
      end
    end
  endtask

  function automatic logic signed [mp2a_pkg::SAMPLE_BITS-1:0] random_sample();
    // a share of repeated values so that ties show up
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return mp2a_pkg::SAMPLE_BITS'(int'($urandom_range(0, 3)) - 2);
      default: return mp2a_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // One sample transfer; valid stays high for a back-to-back successor
  task automatic send_sample(input logic signed [mp2a_pkg::SAMPLE_BITS-1:0] value);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pool_sample(value);
    items_sent++;
  endtask

  // Send random samples until n plane boundaries have been crossed
  task automatic send_planes(input int unsigned n);
    repeat (n) begin
      do send_sample(random_sample());
      while (row_pos != 0 || col_pos != 0);
    end
  endtask

  // Stop offering samples, wait for every pooled result, then let the core settle
  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_transfer(input mp2a_pkg::cfg_reg_t idx,
                              input logic [mp2a_pkg::CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mp2a_pkg::CFG_WINDOW_SIZE:  cfg_window = value[mp2a_pkg::WIN_BITS-1:0];
      mp2a_pkg::CFG_STEP:         cfg_step = value[mp2a_pkg::STEP_BITS-1:0];
      mp2a_pkg::CFG_PLANE_WIDTH:  cfg_width = value[mp2a_pkg::DIM_BITS-1:0];
      mp2a_pkg::CFG_PLANE_HEIGHT: cfg_height = value[mp2a_pkg::DIM_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned win, input int unsigned stride,
                              input int unsigned width, input int unsigned height);
    wait_drained();
    cfg_transfer(mp2a_pkg::CFG_WINDOW_SIZE, mp2a_pkg::CFG_DATA_BITS'(win));
    cfg_transfer(mp2a_pkg::CFG_STEP, mp2a_pkg::CFG_DATA_BITS'(stride));
    cfg_transfer(mp2a_pkg::CFG_PLANE_WIDTH, mp2a_pkg::CFG_DATA_BITS'(width));
    cfg_transfer(mp2a_pkg::CFG_PLANE_HEIGHT, mp2a_pkg::CFG_DATA_BITS'(height));
    cfg_valid <= 1'b0;
  endtask

  // Extreme values, ties and a maximum in the last window corner on a 4x4 plane
  task automatic test_directed_extremes();
    int vals[16] = '{32767, 32767, -32768, -32768,
                     0, 32767, -32768, -1,
                     -5, -5, 100, 3,
                     -5, -5, 3, 100};
    int i;
    set_geometry(2, 2, 4, 4);
    for (i = 0; i < 16; i++) send_sample(mp2a_pkg::SAMPLE_BITS'(vals[i]));
  endtask

  // Zero window, step and sizes act as one: every sample is its own plane
  task automatic test_degenerate_planes();
    set_geometry(0, 0, 0, 0);
    send_planes(260);
  endtask

  // Height above 256 rows; row fields wrap at 8 bits
  task automatic test_tall_plane();
    set_geometry(1, 1, 1, 270);
    send_planes(1);
  endtask

  // Width above the line store saturates; stride above the pool size
  task automatic test_wide_plane();
    set_geometry(1, 9, 300, 1);
    send_planes(1);
  endtask

  // Window above the pool size saturates to the largest window
  task automatic test_window_saturation();
    set_geometry(15, 1, 9, 8);
    send_planes(1);
    set_geometry(8, 15, 16, 8);
    send_planes(1);
  endtask

  // Window larger than the plane never produces a result
  task automatic test_oversized_window();
    set_geometry(5, 1, 4, 6);
    send_planes(1);
    set_geometry(8, 2, 8, 3);
    send_planes(1);
  endtask

  // Shrink the geometry mid-plane; the full 8x8 plane first fills every entry read later
  task automatic test_mid_plane_change();
    set_geometry(3, 1, 8, 8);
    send_planes(1);
    repeat (20) send_sample(random_sample());
    set_geometry(2, 1, 3, 4);
    send_planes(2);
  endtask

  // Long output hold-off while samples keep coming, so the core backs up
  task automatic test_output_backpressure();
    set_geometry(1, 1, 6, 6);
    tx_idle_en = 1'b0;
    hold_request <= hold_request + 1;
    send_planes(1);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_geometry(input int unsigned item_goal);
    int unsigned win, stride, width, height, eff;
    while (items_sent < item_goal) begin
      case ($urandom_range(0, 9))
        0: win = 0;
        1: win = $urandom_range(9, 15);
        default: win = $urandom_range(1, 8);
      endcase
      eff = (win == 0) ? 1 : ((win > mp2a_pkg::MAX_POOL) ? mp2a_pkg::MAX_POOL : win);
      stride = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, eff);
      case ($urandom_range(0, 9))
        0: begin
          width = $urandom_range(17, 40);
          height = $urandom_range(eff, eff + 2);
        end
        1: begin
          width = $urandom_range(1, eff + 2);
          height = $urandom_range(1, eff + 2);
        end
        default: begin
          width = $urandom_range(eff, 16);
          height = $urandom_range(eff, 12);
        end
      endcase
      set_geometry(win, stride, width, height);
      send_planes($urandom_range(1, 2));
    end
  endtask

  // Final stretch with no idling on either side
  task automatic test_quiet_tail();
    tx_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    test_random_geometry(items_sent + 200);
  endtask

  // Result stall: random bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen <= hold_request;
      hold_left <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      result_stall <= 1'b1;
      burst_left <= $urandom_range(0, 11);
    end else begin
      result_stall <= 1'b0;
      burst_left <= $urandom_range(0, 15);
    end
  end

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Compare each result transfer with the oldest pending window
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_windows.size() == 0) begin
        $error("result transfer with no pending window");
        fail_count++;
      end else begin
        got_window = pending_windows.pop_front();
        check_field("max_value", int'(got_window.max_value), int'(max_value));
        check_field("out_row", got_window.out_row, out_row);
        check_field("out_col", got_window.out_col, out_col);
        check_field("channel_index", got_window.channel_index, channel_index);
        check_field("argmax_row", got_window.argmax_row, argmax_row);
        check_field("argmax_col", got_window.argmax_col, argmax_col);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_degenerate_planes();
    test_tall_plane();
    test_wide_plane();
    test_window_saturation();
    test_oversized_window();
    test_mid_plane_change();
    test_output_backpressure();
    test_random_geometry(1750);
    test_quiet_tail();
    wait_drained();
    if (fail_count == 0 && pending_windows.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### max_pool_2d_argmax_core.f
hdl/mp2a_pkg.sv
hdl/mp2a_div.sv
hdl/mp2a_datapath.sv
hdl/mp2a_ctrl.sv
hdl/max_pool_2d_argmax_core.sv
sim/max_pool_2d_argmax_core_tb.sv
